// ===== src/ckvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ckvt_pkg;

   // table geometry
   localparam int ENTRIES     = 16;
   localparam int KEY_BYTES   = 20;
   localparam int CRED_BYTES  = 16;
   localparam int PRIV_BYTES  = 21;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   // request codes
   localparam logic [1:0] REQ_SAVE  = 2'd0;
   localparam logic [1:0] REQ_FIND  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_LIST  = 2'd3;

   // result status codes
   localparam logic [2:0] STS_STORED    = 3'd0;
   localparam logic [2:0] STS_FULL      = 3'd1;
   localparam logic [2:0] STS_FOUND     = 3'd2;
   localparam logic [2:0] STS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STS_CLEARED   = 3'd4;
   localparam logic [2:0] STS_LISTED    = 3'd5;
   localparam logic [2:0] STS_EMPTY     = 3'd6;

   // mask of the bytes in use of a word starting at byte base, at most span bytes wide
   function automatic logic [63:0] byte_mask(int total, int base, int span);
      int n;
      n = total - base;
      if (n > span) n = span;
      if (n <= 0) return 64'd0;
      if (n >= 8) return {64{1'b1}};
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   localparam logic [63:0] KEY_MASK0  = byte_mask(KEY_BYTES, 0, 8);
   localparam logic [63:0] KEY_MASK1  = byte_mask(KEY_BYTES, 8, 8);
   localparam logic [31:0] KEY_MASK2  = 32'(byte_mask(KEY_BYTES, 16, 4));
   localparam logic [63:0] CRED_MASK0 = byte_mask(CRED_BYTES, 0, 8);
   localparam logic [63:0] CRED_MASK1 = byte_mask(CRED_BYTES, 8, 8);
   localparam logic [63:0] PRIV_MASK0 = byte_mask(PRIV_BYTES, 0, 8);
   localparam logic [63:0] PRIV_MASK1 = byte_mask(PRIV_BYTES, 8, 8);
   localparam logic [39:0] PRIV_MASK2 = 40'(byte_mask(PRIV_BYTES, 16, 5));

   // one entry's data, key word 0 in the lowest bits when packed
   typedef struct packed {
      logic [39:0] priv2;
      logic [63:0] priv1;
      logic [63:0] priv0;
      logic [63:0] cred1;
      logic [63:0] cred0;
      logic [31:0] key2;
      logic [63:0] key1;
      logic [63:0] key0;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // write port of the entry store
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } store_wr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_WRITE,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== src/ckvt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ckvt_store (
   input  wire                          clock,
   input  ckvt_pkg::store_wr_type       wr,
   input  wire  [ckvt_pkg::IDX_W-1:0]   rd_addr,
   output ckvt_pkg::entry_type          rd_data
);

   ckvt_pkg::entry_type mem [ckvt_pkg::ENTRIES];
   ckvt_pkg::entry_type rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read, old data on a collision
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/credential_key_value_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                  contents
// req_      in         req_tvalid / req_tready    tuser: request type; tdata: key, id, private key
// rsp_      out        rsp_tvalid / rsp_tready    tuser: status; tlast: last result; tdata: data
//
// one request at a time; one shared key compare, each entry taking a store read, then a compare;
// find stops at the first match, save ends with a write-back or a full status, list emits one
// result per valid entry; clear and empty list go straight to the result; reset clears the
// valid flags and the sequencer, never the store
// a result waits in the output register while the next request may be accepted, and an emit
// step stalls while that register is still full

module credential_key_value_table (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [1:0]   req_tuser,   // req_type
   // key_word0, key_word1, key_word2, cred_word0, cred_word1, priv_word0, priv_word1, priv_word2
   input  wire  [455:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [2:0]   rsp_tuser,   // status
   output logic         rsp_tlast,   // last_item
   // key_out0, key_out1, key_out2, cred_out0, cred_out1, priv_out0, priv_out1, priv_out2
   output logic [455:0] rsp_tdata
);

   localparam logic [ckvt_pkg::IDX_W-1:0] LAST_IDX = ckvt_pkg::IDX_W'(ckvt_pkg::ENTRIES - 1);
   localparam logic [ckvt_pkg::CNT_W-1:0] LAST_CNT =
      ckvt_pkg::CNT_W'(ckvt_pkg::MAX_RESULTS - 1);

   ckvt_pkg::state_type state_ff, state_in;

   logic [1:0]                    req_type_ff, req_type_in;
   ckvt_pkg::entry_type           pl_ff, pl_in;
   logic [ckvt_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          hit_ff, hit_in;
   logic [ckvt_pkg::IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                          free_ff, free_in;
   logic [ckvt_pkg::IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [ckvt_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [2:0]                    pend_status_ff, pend_status_in;
   logic                          pend_last_ff, pend_last_in;
   logic [ckvt_pkg::ENTRIES-1:0]  valid_ff, valid_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [2:0]                    rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;
   ckvt_pkg::entry_type           rsp_data_ff, rsp_data_in;

   ckvt_pkg::store_wr_type        wr;
   ckvt_pkg::entry_type           rd_data;
   ckvt_pkg::entry_type           req_data;

   logic req_acc;
   logic out_free;
   logic last_idx;
   logic valid_at;
   logic key_eq;
   logic match;
   logic more_valid;

   // entry store
   ckvt_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_data   = ckvt_pkg::entry_type'(req_tdata);
   assign req_tready = (state_ff == ckvt_pkg::S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_idx   = (idx_ff == LAST_IDX);
   assign valid_at   = valid_ff[idx_ff];

   // the shared key comparator
   assign key_eq = (rd_data.key0 == pl_ff.key0) && (rd_data.key1 == pl_ff.key1) &&
                   (rd_data.key2 == pl_ff.key2);
   assign match  = valid_at && key_eq;

   // any valid entry beyond the current one
   always_comb begin
      more_valid = 1'b0;
      for (int j = 0; j < ckvt_pkg::ENTRIES; j++) begin
         if (valid_ff[j] && (ckvt_pkg::IDX_W'(j) > idx_ff)) more_valid = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ckvt_pkg::S_IDLE: begin
            if (req_acc) begin
               if ((req_tuser == ckvt_pkg::REQ_CLEAR) ||
                   ((req_tuser == ckvt_pkg::REQ_LIST) && (valid_ff == '0))) begin
                  state_in = ckvt_pkg::S_EMIT;
               end else begin
                  state_in = ckvt_pkg::S_READ;
               end
            end
         end
         ckvt_pkg::S_READ: begin
            state_in = ckvt_pkg::S_CHECK;
         end
         ckvt_pkg::S_CHECK: begin
            case (req_type_ff)
               ckvt_pkg::REQ_SAVE: begin
                  if (match || last_idx) state_in = ckvt_pkg::S_WRITE;
                  else state_in = ckvt_pkg::S_READ;
               end
               ckvt_pkg::REQ_FIND: begin
                  if (match || last_idx) state_in = ckvt_pkg::S_EMIT;
                  else state_in = ckvt_pkg::S_READ;
               end
               ckvt_pkg::REQ_LIST: begin
                  if (valid_at) state_in = ckvt_pkg::S_EMIT;
                  else if (last_idx) state_in = ckvt_pkg::S_IDLE;
                  else state_in = ckvt_pkg::S_READ;
               end
               default: begin
                  state_in = ckvt_pkg::S_IDLE;
               end
            endcase
         end
         ckvt_pkg::S_WRITE: begin
            state_in = ckvt_pkg::S_EMIT;
         end
         ckvt_pkg::S_EMIT: begin
            if (out_free) begin
               if ((req_type_ff == ckvt_pkg::REQ_LIST) && !pend_last_ff) begin
                  state_in = ckvt_pkg::S_READ;
               end else begin
                  state_in = ckvt_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = ckvt_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and store control
   always_comb begin
      req_type_in    = req_type_ff;
      pl_in          = pl_ff;
      idx_in         = idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_data_in    = rsp_data_ff;
      wr.en          = 1'b0;
      wr.addr        = hit_ff ? hit_idx_ff : free_idx_ff;
      wr.data        = pl_ff;
      case (state_ff)
         ckvt_pkg::S_IDLE: begin
            if (req_acc) begin
               req_type_in    = req_tuser;
               pl_in.key0     = req_data.key0 & ckvt_pkg::KEY_MASK0;
               pl_in.key1     = req_data.key1 & ckvt_pkg::KEY_MASK1;
               pl_in.key2     = req_data.key2 & ckvt_pkg::KEY_MASK2;
               pl_in.cred0    = req_data.cred0 & ckvt_pkg::CRED_MASK0;
               pl_in.cred1    = req_data.cred1 & ckvt_pkg::CRED_MASK1;
               pl_in.priv0    = req_data.priv0 & ckvt_pkg::PRIV_MASK0;
               pl_in.priv1    = req_data.priv1 & ckvt_pkg::PRIV_MASK1;
               pl_in.priv2    = req_data.priv2 & ckvt_pkg::PRIV_MASK2;
               idx_in         = '0;
               hit_in         = 1'b0;
               free_in        = 1'b0;
               count_in       = '0;
               pend_last_in   = 1'b1;
               pend_status_in = ckvt_pkg::STS_EMPTY;
               if (req_tuser == ckvt_pkg::REQ_CLEAR) begin
                  valid_in       = '0;
                  pend_status_in = ckvt_pkg::STS_CLEARED;
               end
            end
         end
         ckvt_pkg::S_CHECK: begin
            case (req_type_ff)
               ckvt_pkg::REQ_SAVE: begin
                  if (match) begin
                     hit_in     = 1'b1;
                     hit_idx_in = idx_ff;
                  end else begin
                     if (!valid_at && !free_ff) begin
                        free_in     = 1'b1;
                        free_idx_in = idx_ff;
                     end
                     if (!last_idx) idx_in = idx_ff + 1'b1;
                  end
               end
               ckvt_pkg::REQ_FIND: begin
                  pend_last_in   = 1'b1;
                  pend_status_in = match ? ckvt_pkg::STS_FOUND : ckvt_pkg::STS_NOT_FOUND;
                  if (!match && !last_idx) idx_in = idx_ff + 1'b1;
               end
               ckvt_pkg::REQ_LIST: begin
                  pend_status_in = ckvt_pkg::STS_LISTED;
                  pend_last_in   = !more_valid || (count_ff == LAST_CNT);
                  if (!valid_at && !last_idx) idx_in = idx_ff + 1'b1;
               end
               default: begin
                  pend_last_in = 1'b1;
               end
            endcase
         end
         ckvt_pkg::S_WRITE: begin
            pend_last_in = 1'b1;
            if (hit_ff || free_ff) begin
               wr.en             = 1'b1;
               valid_in[wr.addr] = 1'b1;
               pend_status_in    = ckvt_pkg::STS_STORED;
            end else begin
               pend_status_in    = ckvt_pkg::STS_FULL;
            end
         end
         ckvt_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_last_in   = pend_last_ff;
               rsp_data_in   = '0;
               if (pend_status_ff == ckvt_pkg::STS_LISTED) begin
                  rsp_data_in.key0 = rd_data.key0;
                  rsp_data_in.key1 = rd_data.key1;
                  rsp_data_in.key2 = rd_data.key2;
               end
               if ((pend_status_ff == ckvt_pkg::STS_LISTED) ||
                   (pend_status_ff == ckvt_pkg::STS_FOUND)) begin
                  rsp_data_in.cred0 = rd_data.cred0;
                  rsp_data_in.cred1 = rd_data.cred1;
               end
               if (pend_status_ff == ckvt_pkg::STS_FOUND) begin
                  rsp_data_in.priv0 = rd_data.priv0;
                  rsp_data_in.priv1 = rd_data.priv1;
                  rsp_data_in.priv2 = rd_data.priv2;
               end
               if ((req_type_ff == ckvt_pkg::REQ_LIST) && !pend_last_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            wr.en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ckvt_pkg::S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_type_ff    <= req_type_in;
      pl_ff          <= pl_in;
      idx_ff         <= idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      count_ff       <= count_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an accepted request always starts work
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ckvt_pkg::S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // clear drops every valid flag
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_tuser == ckvt_pkg::REQ_CLEAR)) |=> (valid_ff == '0))
      else $error("valid flags left after clear");

   // a store write marks its entry valid
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> valid_ff[$past(wr.addr)])
      else $error("written entry not marked valid");

   // the output register is only reloaded once free
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== bench/credential_key_value_table_test.sv =====
`timescale 1ns / 1ps

module credential_key_value_table_test;

   localparam int RANDOM_REQUESTS = 445;
   localparam int KEY_POOL_SIZE   = 28;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 80;
   localparam int MAX_REPORTS     = 10;

   // receiver stall patterns
   localparam int RX_ALWAYS   = 0;
   localparam int RX_RANDOM   = 1;
   localparam int RX_PERIODIC = 2;
   localparam int RX_SPARSE   = 3;

   // one result as the block should emit it
   typedef struct packed {
      logic [2:0]          status;
      ckvt_pkg::entry_type data;
      logic                last;
   } table_result_type;

   // one row of the directed stimulus
   typedef struct packed {
      logic [1:0]          kind;
      ckvt_pkg::entry_type item;
      logic                typed;
      logic [2:0]          typed_status;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   wire          req_tready;
   logic [1:0]   req_tuser = '0;
   logic [455:0] req_tdata = '0;
   wire          rsp_tvalid;
   logic         rsp_tready = 1'b0;
   wire  [2:0]   rsp_tuser;
   wire          rsp_tlast;
   wire  [455:0] rsp_tdata;

   // predicted table contents
   logic                table_valid [ckvt_pkg::ENTRIES];
   ckvt_pkg::entry_type table_entry [ckvt_pkg::ENTRIES];
   table_result_type    expected_results[$];

   stim_row_type     stim_rows[$];
   logic [159:0]     key_pool [KEY_POOL_SIZE];

   int mismatch_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int rx_mode = RX_ALWAYS;
   int rx_mode_left = 0;
   int rx_phase = 0;

   credential_key_value_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // works out the results of one request and updates the predicted table
   function automatic void predict_request(input logic [1:0] kind,
                                           input ckvt_pkg::entry_type item);
      ckvt_pkg::entry_type masked;
      table_result_type    res;
      int                  hit;
      int                  open_idx;
      int                  target;
      int                  listed;
      masked       = item;
      masked.key0  = item.key0 & ckvt_pkg::KEY_MASK0;
      masked.key1  = item.key1 & ckvt_pkg::KEY_MASK1;
      masked.key2  = item.key2 & ckvt_pkg::KEY_MASK2;
      masked.cred0 = item.cred0 & ckvt_pkg::CRED_MASK0;
      masked.cred1 = item.cred1 & ckvt_pkg::CRED_MASK1;
      masked.priv0 = item.priv0 & ckvt_pkg::PRIV_MASK0;
      masked.priv1 = item.priv1 & ckvt_pkg::PRIV_MASK1;
      masked.priv2 = item.priv2 & ckvt_pkg::PRIV_MASK2;
      res = '0;
      res.last = 1'b1;
      hit = -1;
      open_idx = -1;
      // first valid entry with the same key, and the lowest free entry
      for (int i = 0; i < ckvt_pkg::ENTRIES; i++) begin
         if (table_valid[i]) begin
            if (hit < 0 && table_entry[i].key0 == masked.key0 &&
                table_entry[i].key1 == masked.key1 && table_entry[i].key2 == masked.key2)
               hit = i;
         end else if (open_idx < 0) begin
            open_idx = i;
         end
      end
      case (kind)
         ckvt_pkg::REQ_SAVE: begin
            target = (hit >= 0) ? hit : open_idx;
            if (target < 0) begin
               res.status = ckvt_pkg::STS_FULL;
            end else begin
               table_valid[target] = 1'b1;
               table_entry[target] = masked;
               res.status = ckvt_pkg::STS_STORED;
            end
            expected_results.push_back(res);
         end
         ckvt_pkg::REQ_FIND: begin
            if (hit < 0) begin
               res.status = ckvt_pkg::STS_NOT_FOUND;
            end else begin
               res.status     = ckvt_pkg::STS_FOUND;
               res.data.cred0 = table_entry[hit].cred0;
               res.data.cred1 = table_entry[hit].cred1;
               res.data.priv0 = table_entry[hit].priv0;
               res.data.priv1 = table_entry[hit].priv1;
               res.data.priv2 = table_entry[hit].priv2;
            end
            expected_results.push_back(res);
         end
         ckvt_pkg::REQ_CLEAR: begin
            for (int i = 0; i < ckvt_pkg::ENTRIES; i++) table_valid[i] = 1'b0;
            res.status = ckvt_pkg::STS_CLEARED;
            expected_results.push_back(res);
         end
         default: begin
            // one listed entry per valid entry, the last one marked
            listed = 0;
            for (int i = 0; i < ckvt_pkg::ENTRIES && listed < ckvt_pkg::MAX_RESULTS; i++) begin
               if (table_valid[i]) begin
                  res            = '0;
                  res.status     = ckvt_pkg::STS_LISTED;
                  res.data.key0  = table_entry[i].key0;
                  res.data.key1  = table_entry[i].key1;
                  res.data.key2  = table_entry[i].key2;
                  res.data.cred0 = table_entry[i].cred0;
                  res.data.cred1 = table_entry[i].cred1;
                  expected_results.push_back(res);
                  listed++;
               end
            end
            if (listed == 0) begin
               res.status = ckvt_pkg::STS_EMPTY;
               expected_results.push_back(res);
            end else begin
               res      = expected_results.pop_back();
               res.last = 1'b1;
               expected_results.push_back(res);
            end
         end
      endcase
   endfunction

   // entry with the given key and random id and private key
   function automatic ckvt_pkg::entry_type random_entry(input logic [159:0] key);
      ckvt_pkg::entry_type e;
      logic [63:0]         w;
      e.key0  = key[63:0];
      e.key1  = key[127:64];
      e.key2  = key[159:128];
      e.cred0 = {$urandom, $urandom};
      e.cred1 = {$urandom, $urandom};
      e.priv0 = {$urandom, $urandom};
      e.priv1 = {$urandom, $urandom};
      w       = {$urandom, $urandom};
      e.priv2 = w[39:0];
      return e;
   endfunction

   function automatic stim_row_type make_row(input logic [1:0] kind,
                                             input ckvt_pkg::entry_type item,
                                             input logic typed, input logic [2:0] status);
      stim_row_type row;
      row.kind         = kind;
      row.item         = item;
      row.typed        = typed;
      row.typed_status = status;
      return row;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
   endfunction

   // sender: bursts of requests with random gaps between them
   task automatic issue_request(input logic [1:0] kind, input ckvt_pkg::entry_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(kind, item);
   endtask

   // receiver stalls, switching pattern now and then
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = $urandom_range(RX_ALWAYS, RX_SPARSE);
         rx_mode_left = $urandom_range(50, 300);
      end else begin
         rx_mode_left--;
      end
      rx_phase++;
      case (rx_mode)
         RX_ALWAYS:   rsp_tready <= 1'b1;
         RX_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_PERIODIC: rsp_tready <= (rx_phase % 8) >= 3;
         default:     rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // result checking against the oldest expectation
   always @(posedge clock) begin
      table_result_type    want;
      ckvt_pkg::entry_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = ckvt_pkg::entry_type'(rsp_tdata);
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result with status %0d", rsp_tuser);
         end else begin
            want = expected_results.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_tuser));
            check_field("key_out0", want.data.key0, got.key0);
            check_field("key_out1", want.data.key1, got.key1);
            check_field("key_out2", 64'(want.data.key2), 64'(got.key2));
            check_field("cred_out0", want.data.cred0, got.cred0);
            check_field("cred_out1", want.data.cred1, got.cred1);
            check_field("priv_out0", want.data.priv0, got.priv0);
            check_field("priv_out1", want.data.priv1, got.priv1);
            check_field("priv_out2", 64'(want.data.priv2), 64'(got.priv2));
            check_field("last_item", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL credential_key_value_table");
         $finish;
      end
   end

   initial begin
      table_result_type    typed_res;
      ckvt_pkg::entry_type item;
      logic [159:0]        key;
      logic [159:0]        ones_key;
      logic [1:0]          kind;
      int                  pick;
      ones_key = '1;
      for (int i = 0; i < ckvt_pkg::ENTRIES; i++) begin
         table_valid[i] = 1'b0;
         table_entry[i] = '0;
      end

      // directed: empty table, extremes, rewrite on match, full table, clear
      stim_rows.push_back(make_row(ckvt_pkg::REQ_LIST, random_entry('0), 1'b1,
                                   ckvt_pkg::STS_EMPTY));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_FIND, random_entry('0), 1'b1,
                                   ckvt_pkg::STS_NOT_FOUND));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_SAVE, '0, 1'b1, ckvt_pkg::STS_STORED));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_SAVE, '1, 1'b1, ckvt_pkg::STS_STORED));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_FIND, random_entry(ones_key), 1'b0,
                                   ckvt_pkg::STS_STORED));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_SAVE, random_entry(ones_key), 1'b1,
                                   ckvt_pkg::STS_STORED));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_FIND, random_entry(ones_key), 1'b0,
                                   ckvt_pkg::STS_STORED));
      for (int i = 0; i < ckvt_pkg::ENTRIES - 2; i++)
         stim_rows.push_back(make_row(ckvt_pkg::REQ_SAVE, random_entry(160'd1 << (i * 11)),
                                      1'b1, ckvt_pkg::STS_STORED));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_SAVE, random_entry({5{32'ha5a5_5a5a}}),
                                   1'b1, ckvt_pkg::STS_FULL));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_LIST, random_entry('0), 1'b0,
                                   ckvt_pkg::STS_STORED));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_FIND, random_entry('0), 1'b0,
                                   ckvt_pkg::STS_STORED));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_CLEAR, random_entry(ones_key), 1'b1,
                                   ckvt_pkg::STS_CLEARED));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_FIND, random_entry(ones_key), 1'b1,
                                   ckvt_pkg::STS_NOT_FOUND));
      stim_rows.push_back(make_row(ckvt_pkg::REQ_LIST, random_entry('0), 1'b1,
                                   ckvt_pkg::STS_EMPTY));

      // keys for the random part: extremes, random keys and near misses one bit apart
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_SIZE; i++) begin
         if (i % 2 == 1)
            key_pool[i] = key_pool[i - 1] ^ (160'd1 << $urandom_range(0, 159));
         else
            key_pool[i] = {$urandom, $urandom, $urandom, $urandom, $urandom};
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         issue_request(stim_rows[r].kind, stim_rows[r].item);
         if (stim_rows[r].typed) begin
            typed_res        = '0;
            typed_res.status = stim_rows[r].typed_status;
            typed_res.last   = 1'b1;
            void'(expected_results.pop_back());
            expected_results.push_back(typed_res);
         end
      end

      // random requests, mostly on a small set of keys so that entries match and fill up
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            kind = ckvt_pkg::REQ_SAVE;
         else if (pick < 82)
            kind = ckvt_pkg::REQ_FIND;
         else if (pick < 98)
            kind = ckvt_pkg::REQ_LIST;
         else
            kind = ckvt_pkg::REQ_CLEAR;
         if ($urandom_range(0, 9) == 0)
            key = {$urandom, $urandom, $urandom, $urandom, $urandom};
         else
            key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
         item = random_entry(key);
         issue_request(kind, item);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then allow for stray results
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS credential_key_value_table");
      else
         $display("FAIL credential_key_value_table");
      $finish;
   end

endmodule
